### rtl/trsmm_pkg.sv
// shared types, constants and functions for the trs model matrix builder
// no dependencies
`default_nettype none
package trsmm_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int NSTG = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  // cordic datapath width, Q.30 with headroom
  localparam int CW = 36;
  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = CW'(652032874);
  localparam logic signed [16:0] PI_Q13      = 17'sd25736;
  localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;
  // cordic registers plus the reduction register
  localparam int CLAT = NSTG + 1;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
  } out_t;

  function automatic logic signed [31:0] atan_q30(input logic [4:0] idx);
    logic signed [31:0] v;
    unique case (idx)
      5'd0:  v = 32'sd843314857;
      5'd1:  v = 32'sd497837829;
      5'd2:  v = 32'sd263043837;
      5'd3:  v = 32'sd133525159;
      5'd4:  v = 32'sd67021687;
      5'd5:  v = 32'sd33543516;
      5'd6:  v = 32'sd16775851;
      5'd7:  v = 32'sd8388437;
      5'd8:  v = 32'sd4194283;
      5'd9:  v = 32'sd2097149;
      5'd10: v = 32'sd1048576;
      5'd11: v = 32'sd524288;
      5'd12: v = 32'sd262144;
      5'd13: v = 32'sd131072;
      5'd14: v = 32'sd65536;
      5'd15: v = 32'sd32768;
      5'd16: v = 32'sd16384;
      5'd17: v = 32'sd8192;
      5'd18: v = 32'sd4096;
      5'd19: v = 32'sd2048;
      5'd20: v = 32'sd1024;
      5'd21: v = 32'sd512;
      5'd22: v = 32'sd256;
      5'd23: v = 32'sd128;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### rtl/trsmm_cordic.sv
// pipelined rotation-mode cordic: quadrant fold, then one register per stage
// depends on trsmm_pkg
`default_nettype none
module trsmm_cordic (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [15:0] angle,
  output logic signed [31:0]      sin_o,
  output logic signed [31:0]      cos_o
);
  import trsmm_pkg::*;

  logic signed [CW-1:0] x_r [NSTG+1];
  logic signed [CW-1:0] y_r [NSTG+1];
  logic signed [CW-1:0] z_r [NSTG+1];
  logic                 flip_r [NSTG+1];

  logic signed [16:0] a_wide;
  logic signed [16:0] a_red;
  logic               flip_nxt;

  always_comb begin
    a_wide = {angle[15], angle};
    a_red = a_wide;
    flip_nxt = 1'b0;
    if (a_wide > HALF_PI_Q13) begin
      a_red = a_wide - PI_Q13;
      flip_nxt = 1'b1;
    end else if (a_wide < -HALF_PI_Q13) begin
      a_red = a_wide + PI_Q13;
      flip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CORDIC_GAIN_Q30;
      y_r[0] <= '0;
      // Q3.13 to Q.30
      z_r[0] <= {{(CW-34){a_red[16]}}, a_red, 17'b0};
      flip_r[0] <= flip_nxt;
    end
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_stage
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] at;
    assign dx = x_r[i] >>> i;
    assign dy = y_r[i] >>> i;
    assign at = CW'(atan_q30(5'(i)));
    always_ff @(posedge clk) begin
      if (en) begin
        flip_r[i+1] <= flip_r[i];
        if (!z_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] - dy;
          y_r[i+1] <= y_r[i] + dx;
          z_r[i+1] <= z_r[i] - at;
        end else begin
          x_r[i+1] <= x_r[i] + dy;
          y_r[i+1] <= y_r[i] - dx;
          z_r[i+1] <= z_r[i] + at;
        end
      end
    end
  end

  logic signed [CW-1:0] xf;
  logic signed [CW-1:0] yf;
  assign xf = flip_r[NSTG] ? -x_r[NSTG] : x_r[NSTG];
  assign yf = flip_r[NSTG] ? -y_r[NSTG] : y_r[NSTG];
  assign cos_o = xf[31:0];
  assign sin_o = yf[31:0];

endmodule
`default_nettype wire

### rtl/trsmm_matrix.sv
// rotation product and per-column scaling in four register stages
// depends on trsmm_pkg
`default_nettype none
module trsmm_matrix (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               vld_i,
  input  wire logic signed [31:0] sx,
  input  wire logic signed [31:0] cx,
  input  wire logic signed [31:0] sy,
  input  wire logic signed [31:0] cy,
  input  wire logic signed [31:0] sz,
  input  wire logic signed [31:0] cz,
  input  wire trsmm_pkg::in_t     pose,
  output logic                    vld_o,
  output trsmm_pkg::out_t         res_o
);
  import trsmm_pkg::*;

  function automatic logic signed [31:0] rnd64(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + 64'sd536870912) >>> 30;
    return t[31:0];
  endfunction

  function automatic logic signed [31:0] satrnd(input logic signed [64:0] p);
    logic signed [64:0] t;
    t = (p + 65'sd536870912) >>> 30;
    if (t > 65'sd2147483647) return 32'sh7fffffff;
    else if (t < -65'sd2147483648) return 32'sh80000000;
    else return t[31:0];
  endfunction

  logic [3:0] vld_r;

  // stage 1: first-level products
  logic signed [63:0] p_czcy_r, p_czsy_r, p_szcx_r, p_szsx_r, p_szcy_r;
  logic signed [63:0] p_szsy_r, p_czcx_r, p_czsx_r, p_cysx_r, p_cycx_r;
  logic signed [31:0] sx1_r, cx1_r, sy1_r;
  in_t                pose1_r;

  // stage 2: second-level products and rounded terms
  logic signed [63:0] q_asx_r, q_acx_r, q_bsx_r, q_bcx_r;
  logic signed [31:0] r0_r, t_szcx_r, t_szsx_r, r3_r, t_czcx_r, t_czsx_r, r7_r, r8_r;
  logic signed [32:0] nsy_r;
  in_t                pose2_r;

  // stage 3: entries times scale
  logic signed [64:0] prod_r [9];
  in_t                pose3_r;

  logic signed [31:0] a_rnd, b_rnd;
  logic signed [32:0] rent [9];
  logic signed [31:0] scl [3];

  assign a_rnd = rnd64(p_czsy_r);
  assign b_rnd = rnd64(p_szsy_r);

  always_comb begin
    rent[0] = {r0_r[31], r0_r};
    rent[1] = 33'(rnd64(q_asx_r)) - 33'(t_szcx_r);
    rent[2] = 33'(rnd64(q_acx_r)) + 33'(t_szsx_r);
    rent[3] = {r3_r[31], r3_r};
    rent[4] = 33'(rnd64(q_bsx_r)) + 33'(t_czcx_r);
    rent[5] = 33'(rnd64(q_bcx_r)) - 33'(t_czsx_r);
    rent[6] = nsy_r;
    rent[7] = {r7_r[31], r7_r};
    rent[8] = {r8_r[31], r8_r};
    scl[0] = pose2_r.scale_x;
    scl[1] = pose2_r.scale_y;
    scl[2] = pose2_r.scale_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_czcy_r <= cz * cy;
      p_czsy_r <= cz * sy;
      p_szcx_r <= sz * cx;
      p_szsx_r <= sz * sx;
      p_szcy_r <= sz * cy;
      p_szsy_r <= sz * sy;
      p_czcx_r <= cz * cx;
      p_czsx_r <= cz * sx;
      p_cysx_r <= cy * sx;
      p_cycx_r <= cy * cx;
      sx1_r <= sx;
      cx1_r <= cx;
      sy1_r <= sy;
      pose1_r <= pose;

      q_asx_r <= a_rnd * sx1_r;
      q_acx_r <= a_rnd * cx1_r;
      q_bsx_r <= b_rnd * sx1_r;
      q_bcx_r <= b_rnd * cx1_r;
      r0_r <= rnd64(p_czcy_r);
      t_szcx_r <= rnd64(p_szcx_r);
      t_szsx_r <= rnd64(p_szsx_r);
      r3_r <= rnd64(p_szcy_r);
      t_czcx_r <= rnd64(p_czcx_r);
      t_czsx_r <= rnd64(p_czsx_r);
      r7_r <= rnd64(p_cysx_r);
      r8_r <= rnd64(p_cycx_r);
      nsy_r <= -{sy1_r[31], sy1_r};
      pose2_r <= pose1_r;

      for (int k = 0; k < 9; k++) begin
        prod_r[k] <= rent[k] * scl[k % 3];
      end
      pose3_r <= pose2_r;

      res_o.m00 <= satrnd(prod_r[0]);
      res_o.m01 <= satrnd(prod_r[1]);
      res_o.m02 <= satrnd(prod_r[2]);
      res_o.m10 <= satrnd(prod_r[3]);
      res_o.m11 <= satrnd(prod_r[4]);
      res_o.m12 <= satrnd(prod_r[5]);
      res_o.m20 <= satrnd(prod_r[6]);
      res_o.m21 <= satrnd(prod_r[7]);
      res_o.m22 <= satrnd(prod_r[8]);
      res_o.tx <= pose3_r.pos_x;
      res_o.ty <= pose3_r.pos_y;
      res_o.tz <= pose3_r.pos_z;
    end
  end

  assign vld_o = vld_r[3];

endmodule
`default_nettype wire

### rtl/trs_model_matrix_builder.sv
// throughput: one pose per cycle; the whole pipeline holds while the output beat is stalled
// depth set by the cordic stage chain plus four multiply/round stages
// reset clears only the valid bits; data registers are not reset
// depends on trsmm_pkg, trsmm_cordic, trsmm_matrix
`default_nettype none
module trs_model_matrix_builder (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire trsmm_pkg::in_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output trsmm_pkg::out_t      out_data
);
  import trsmm_pkg::*;

  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  logic signed [31:0] sx, cx, sy, cy, sz, cz;

  trsmm_cordic u_cx (.clk(clk), .en(adv), .angle(in_data.angle_x), .sin_o(sx), .cos_o(cx));
  trsmm_cordic u_cy (.clk(clk), .en(adv), .angle(in_data.angle_y), .sin_o(sy), .cos_o(cy));
  trsmm_cordic u_cz (.clk(clk), .en(adv), .angle(in_data.angle_z), .sin_o(sz), .cos_o(cz));

  // pose and valid travel alongside the cordic stages
  logic vld_r [CLAT];
  in_t  pose_r [CLAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CLAT; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < CLAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pose_r[0] <= in_data;
      for (int k = 1; k < CLAT; k++) pose_r[k] <= pose_r[k-1];
    end
  end

  trsmm_matrix u_mat (
    .clk(clk), .rst_n(rst_n), .en(adv), .vld_i(vld_r[CLAT-1]),
    .sx(sx), .cx(cx), .sy(sy), .cy(cy), .sz(sz), .cz(cz),
    .pose(pose_r[CLAT-1]), .vld_o(out_valid), .res_o(out_data)
  );

endmodule
`default_nettype wire

### rtl/trsmm_checker.sv
// port-level checks for trs_model_matrix_builder, bound to the top level
// depends on trsmm_pkg
`default_nettype none
module trsmm_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_stall,
  input wire logic            out_valid,
  input wire logic            out_stall,
  input wire trsmm_pkg::out_t out_data
);
  // no beat comes out of reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // input backpressure only comes from a stalled result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output stall");

  a_stall_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while result stalled");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat changed");
endmodule

bind trs_model_matrix_builder trsmm_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire
